FILE: rtl/core/cts_pkg.sv
// cts_pkg: types, constants and helpers for the cylindrical tensor component
// used by the top level and the testbench
// no dependencies
package cts_pkg;

    localparam int unsigned Q_W     = 32;
    localparam int unsigned N_COMP  = 9;
    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_ROW_SEL  = 2'd2,
        CFG_COL_SEL  = 2'd3
    } t_cfg_idx;

    // component selector codes, code three acts as axial
    localparam logic [1:0] SEL_RADIAL = 2'd0;
    localparam logic [1:0] SEL_HOOP   = 2'd1;

    // element 3*k+l holds row k column l
    typedef logic [N_COMP-1:0][Q_W-1:0] t_tensor;
    typedef logic [2:0][Q_W-1:0]        t_row;

    // sideband carried through the square root
    typedef struct packed {
        logic [30:0] an;
        logic [30:0] bn;
        logic        sx;
        logic        sy;
        logic        zero;
        t_tensor     tens;
    } t_sq_sb;

    // sideband carried through the dividers
    typedef struct packed {
        logic    sx;
        logic    sy;
        logic    zero;
        t_tensor tens;
    } t_dv_sb;

    // one row of the rotation about z
    function automatic t_row rot_row(input logic signed [31:0] c,
                                     input logic signed [31:0] s,
                                     input logic [1:0] sel);
        t_row row;
        case (sel)
            SEL_RADIAL: begin
                row[0] = c;
                row[1] = s;
                row[2] = '0;
            end
            SEL_HOOP: begin
                row[0] = -s;
                row[1] = c;
                row[2] = '0;
            end
            default: begin
                row[0] = '0;
                row[1] = '0;
                row[2] = Q30_ONE;
            end
        endcase
        return row;
    endfunction

endpackage

FILE: rtl/core/cts_ifs.sv
// cts channel interfaces: point/tensor input, component output, config writes
// depends on nothing but the signal widths of the block
interface cts_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] t_xx;
    logic signed [31:0] t_xy;
    logic signed [31:0] t_xz;
    logic signed [31:0] t_yx;
    logic signed [31:0] t_yy;
    logic signed [31:0] t_yz;
    logic signed [31:0] t_zx;
    logic signed [31:0] t_zy;
    logic signed [31:0] t_zz;

    modport source (output valid, pos_x, pos_y, t_xx, t_xy, t_xz, t_yx, t_yy, t_yz,
                    t_zx, t_zy, t_zz, input ready);
    modport sink (input valid, pos_x, pos_y, t_xx, t_xy, t_xz, t_yx, t_yy, t_yz,
                  t_zx, t_zy, t_zz, output ready);
endinterface

interface cts_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] component;

    modport source (output valid, component, input ready);
    modport sink (input valid, component, output ready);
endinterface

interface cts_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/cts_sqrt.sv
// cts_sqrt: pipelined integer square root, one result bit per stage
// carries an opaque sideband alongside; used by the top level
module cts_sqrt #(
    parameter int unsigned SB_W = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_q,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_valid,
    output logic [31:0]     o_root,
    output logic [SB_W-1:0] o_sb
);

    localparam int unsigned N = 32;

    logic            r_vld  [0:N];
    logic [34:0]     r_rem  [0:N];
    logic [31:0]     r_root [0:N];
    logic [63:0]     r_q    [0:N];
    logic [SB_W-1:0] r_sb   [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_q[0]    <= i_q;
            r_sb[0]   <= i_sb;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam int unsigned B = N - 1 - g;
        logic [34:0] n_t;
        logic [34:0] n_trial;
        logic [34:0] n_rem;
        logic [31:0] n_root;

        always_comb begin
            n_t     = {r_rem[g][32:0], r_q[g][2*B+1 -: 2]};
            n_trial = {1'b0, r_root[g], 2'b01};
            if (n_t >= n_trial) begin
                n_rem  = n_t - n_trial;
                n_root = {r_root[g][30:0], 1'b1};
            end else begin
                n_rem  = n_t;
                n_root = {r_root[g][30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= n_rem;
                r_root[g+1] <= n_root;
                r_q[g+1]    <= r_q[g];
                r_sb[g+1]   <= r_sb[g];
            end
        end
    end

    assign o_valid = r_vld[N];
    assign o_root  = r_root[N];
    assign o_sb    = r_sb[N];

endmodule

FILE: rtl/core/cts_div.sv
// cts_div: two pipelined restoring dividers sharing one divisor
// quotients are known to fit 31 bits; carries an opaque sideband
module cts_div #(
    parameter int unsigned SB_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [31:0]      i_den,
    input  logic [1:0][61:0] i_num,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [1:0][30:0] o_quo,
    output logic [SB_W-1:0]  o_sb
);

    localparam int unsigned N = 31;

    logic             r_vld [0:N];
    logic [31:0]      r_den [0:N];
    logic [1:0][31:0] r_rem [0:N];
    logic [1:0][30:0] r_quo [0:N];
    logic [1:0][30:0] r_low [0:N];
    logic [SB_W-1:0]  r_sb  [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            for (int ln = 0; ln < 2; ln++) begin
                r_rem[0][ln] <= {1'b0, i_num[ln][61:31]};
                r_low[0][ln] <= i_num[ln][30:0];
            end
            r_quo[0] <= '0;
            r_sb[0]  <= i_sb;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam int unsigned K = N - 1 - g;
        logic [1:0][31:0] n_rem;
        logic [1:0][30:0] n_quo;
        logic [32:0]      n_t;
        logic [32:0]      n_d;

        always_comb begin
            n_rem = r_rem[g];
            n_quo = r_quo[g];
            n_t   = '0;
            n_d   = {1'b0, r_den[g]};
            for (int ln = 0; ln < 2; ln++) begin
                n_t = {r_rem[g][ln], r_low[g][ln][K]};
                if (n_t >= n_d) begin
                    n_rem[ln] = 32'(n_t - n_d);
                    n_quo[ln] = {r_quo[g][ln][29:0], 1'b1};
                end else begin
                    n_rem[ln] = n_t[31:0];
                    n_quo[ln] = {r_quo[g][ln][29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g+1] <= r_den[g];
                r_rem[g+1] <= n_rem;
                r_quo[g+1] <= n_quo;
                r_low[g+1] <= r_low[g];
                r_sb[g+1]  <= r_sb[g];
            end
        end
    end

    assign o_valid = r_vld[N];
    assign o_quo   = r_quo[N];
    assign o_sb    = r_sb[N];

endmodule

FILE: rtl/core/cylindrical_tensor_component_top.sv
// cylindrical_tensor_component_top: rotates a 3x3 tensor into (radial, hoop,
// axial) axes about a configured center and returns one selected component.
// Input: i_in carries the point and nine tensor components, Q16.16.
// Output: o_out carries the saturated component, one per input transfer.
// Config: i_cfg writes center_x, center_y, row_sel, col_sel (index 0..3);
// always ready, write only while no item is in flight.
// Depth: most of the pipeline lies in the 32-stage square root and the
// 31-stage dividers.
// Throughput: one item per cycle unless stalled; every stage is registered.
// Stall: when the output register holds an untaken result the whole pipeline
// freezes and i_in.ready drops in the same cycle; nothing is lost or doubled.
// Reset clears all valid bits and the config registers to zero.
module cylindrical_tensor_component_top
    import cts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cts_in_if.sink      i_in,
    cts_out_if.source   o_out,
    cts_cfg_if.sink     i_cfg
);

    // config
    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic [1:0]         r_row_sel;
    logic [1:0]         r_col_sel;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_row_sel  <= '0;
            r_col_sel  <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_CENTER_X: r_center_x <= i_cfg.data;
                CFG_CENTER_Y: r_center_y <= i_cfg.data;
                CFG_ROW_SEL:  r_row_sel  <= i_cfg.data[1:0];
                CFG_COL_SEL:  r_col_sel  <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_valid;
    logic signed [31:0] r_out_comp;

    assign w_en        = !r_out_valid || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_out_valid;
    assign o_out.component = r_out_comp;

    // stage 1: offsets
    logic               r1_vld;
    logic signed [32:0] r1_dx;
    logic signed [32:0] r1_dy;
    t_tensor            r1_tens;

    // stage 2: magnitudes
    logic        r2_vld;
    logic [32:0] r2_ax;
    logic [32:0] r2_ay;
    logic        r2_sx;
    logic        r2_sy;
    logic        r2_zero;
    t_tensor     r2_tens;

    // stage 3: normalized
    logic   r3_vld;
    t_sq_sb r3_sb;

    // stage 4: squares
    logic        r4_vld;
    logic [61:0] r4_sa;
    logic [61:0] r4_sb2;
    t_sq_sb      r4_sb;

    // divider output valid
    logic w_dv_valid;

    // stage 5: rotation rows
    logic    r5_vld;
    t_row    r5_a;
    t_row    r5_b;
    t_tensor r5_tens;

    // stage 6: tensor times column row
    logic               r6_vld;
    logic signed [63:0] r6_p [0:N_COMP-1];
    t_row               r6_a;

    // stage 7: rounded intermediate vector
    logic               r7_vld;
    logic signed [35:0] r7_v [0:2];
    t_row               r7_a;

    // stage 8: row times vector
    logic               r8_vld;
    logic signed [67:0] r8_m [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r4_vld      <= 1'b0;
            r5_vld      <= 1'b0;
            r6_vld      <= 1'b0;
            r7_vld      <= 1'b0;
            r8_vld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_vld      <= i_in.valid;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r4_vld      <= r3_vld;
            r5_vld      <= w_dv_valid;
            r6_vld      <= r5_vld;
            r7_vld      <= r6_vld;
            r8_vld      <= r7_vld;
            r_out_valid <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx   <= 33'(i_in.pos_x) - 33'(r_center_x);
            r1_dy   <= 33'(i_in.pos_y) - 33'(r_center_y);
            r1_tens <= {i_in.t_zz, i_in.t_zy, i_in.t_zx, i_in.t_yz, i_in.t_yy,
                        i_in.t_yx, i_in.t_xz, i_in.t_xy, i_in.t_xx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ax   <= r1_dx[32] ? 33'(-r1_dx) : r1_dx;
            r2_ay   <= r1_dy[32] ? 33'(-r1_dy) : r1_dy;
            r2_sx   <= r1_dx[32];
            r2_sy   <= r1_dy[32];
            r2_zero <= (r1_dx == '0) && (r1_dy == '0);
            r2_tens <= r1_tens;
        end
    end

    // bring the larger magnitude into [2^30, 2^31)
    logic [32:0] w_m;
    logic [5:0]  w_msb;
    logic [32:0] w_ax_sh;
    logic [32:0] w_ay_sh;

    always_comb begin
        w_m   = (r2_ax > r2_ay) ? r2_ax : r2_ay;
        w_msb = '0;
        for (int b = 0; b < 33; b++) begin
            if (w_m[b]) begin
                w_msb = 6'(b);
            end
        end
        if (w_msb <= 6'd30) begin
            w_ax_sh = r2_ax << (6'd30 - w_msb);
            w_ay_sh = r2_ay << (6'd30 - w_msb);
        end else begin
            w_ax_sh = r2_ax >> (w_msb - 6'd30);
            w_ay_sh = r2_ay >> (w_msb - 6'd30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sb.an   <= w_ax_sh[30:0];
            r3_sb.bn   <= w_ay_sh[30:0];
            r3_sb.sx   <= r2_sx;
            r3_sb.sy   <= r2_sy;
            r3_sb.zero <= r2_zero;
            r3_sb.tens <= r2_tens;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sa  <= 62'(r3_sb.an) * 62'(r3_sb.an);
            r4_sb2 <= 62'(r3_sb.bn) * 62'(r3_sb.bn);
            r4_sb  <= r3_sb;
        end
    end

    // radius
    logic        w_sq_valid;
    logic [31:0] w_root;
    t_sq_sb      w_sq_sb;

    cts_sqrt #(
        .SB_W ($bits(t_sq_sb))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_vld),
        .i_q     (64'(r4_sa) + 64'(r4_sb2)),
        .i_sb    (r4_sb),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_sb    (w_sq_sb)
    );

    // cos and sin magnitudes, rounded to nearest
    logic [1:0][61:0] w_num;
    t_dv_sb           w_dv_in;
    logic [1:0][30:0] w_quo;
    t_dv_sb           w_dv_sb;

    always_comb begin
        w_num[0] = {w_sq_sb.an, 30'd0} + 62'(w_root[31:1]);
        w_num[1] = {w_sq_sb.bn, 30'd0} + 62'(w_root[31:1]);
        w_dv_in.sx   = w_sq_sb.sx;
        w_dv_in.sy   = w_sq_sb.sy;
        w_dv_in.zero = w_sq_sb.zero;
        w_dv_in.tens = w_sq_sb.tens;
    end

    cts_div #(
        .SB_W ($bits(t_dv_sb))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_den   (w_root),
        .i_num   (w_num),
        .i_sb    (w_dv_in),
        .o_valid (w_dv_valid),
        .o_quo   (w_quo),
        .o_sb    (w_dv_sb)
    );

    logic signed [31:0] w_c;
    logic signed [31:0] w_s;

    always_comb begin
        if (w_dv_sb.zero) begin
            // point on the axis
            w_c = Q30_ONE;
            w_s = '0;
        end else begin
            w_c = w_dv_sb.sx ? -$signed({1'b0, w_quo[0]}) : $signed({1'b0, w_quo[0]});
            w_s = w_dv_sb.sy ? -$signed({1'b0, w_quo[1]}) : $signed({1'b0, w_quo[1]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_a    <= rot_row(w_c, w_s, r_row_sel);
            r5_b    <= rot_row(w_c, w_s, r_col_sel);
            r5_tens <= w_dv_sb.tens;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int l = 0; l < 3; l++) begin
                    r6_p[3*k+l] <= 64'($signed(r5_tens[3*k+l])) * 64'($signed(r5_b[l]));
                end
            end
            r6_a <= r5_a;
        end
    end

    logic signed [65:0] w_vs [0:2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_vs[k] = 66'(r6_p[3*k]) + 66'(r6_p[3*k+1]) + 66'(r6_p[3*k+2])
                      + 66'sd536870912;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r7_v[k] <= w_vs[k][65:30];
            end
            r7_a <= r6_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r8_m[k] <= 68'($signed(r7_a[k])) * 68'(r7_v[k]);
            end
        end
    end

    logic signed [69:0] w_acc;
    logic signed [39:0] w_rnd;

    always_comb begin
        w_acc = 70'(r8_m[0]) + 70'(r8_m[1]) + 70'(r8_m[2]) + 70'sd536870912;
        w_rnd = w_acc[69:30];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_rnd > 40'sd2147483647) begin
                r_out_comp <= 32'sh7fff_ffff;
            end else if (w_rnd < -40'sd2147483648) begin
                r_out_comp <= 32'sh8000_0000;
            end else begin
                r_out_comp <= w_rnd[31:0];
            end
        end
    end

`ifndef SYNTHESIS
    // normalization leaves the larger magnitude with bit 30 as its top bit
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld && !r3_sb.zero |-> (r3_sb.an[30] || r3_sb.bn[30]))
        else $error("normalized magnitude out of range");

    // the radius of a normalized point is at least 2^30
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_valid && !w_sq_sb.zero |-> w_root[31:30] != 2'b00)
        else $error("radius below normalized range");

    // cos and sin magnitudes never exceed one
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_valid && !w_dv_sb.zero |->
            (w_quo[0] <= 31'h4000_0000) && (w_quo[1] <= 31'h4000_0000))
        else $error("direction cosine above one");
`endif

endmodule

FILE: dv/tb_cylindrical_tensor_component_top.sv
// testbench for cylindrical_tensor_component_top: directed and random points/tensors,
// config phases, receiver back-pressure; results checked against an in-bench predictor
// depends on cts_pkg, cts_ifs and the top level rtl
module tb_cylindrical_tensor_component_top;
    import cts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] SEL_ALIAS = 2'd3;  // decodes as axial
    localparam int unsigned DRAIN_CYCLES = 100;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] t [9];
    } t_point;

    logic i_clk;
    logic i_rst_n;

    cts_in_if  in_ch();
    cts_out_if out_ch();
    cts_cfg_if cfg_ch();

    cylindrical_tensor_component_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // shadow of the config registers
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic [1:0]         sel_row;
    logic [1:0]         sel_col;

    logic signed [31:0] expected_components [$];
    int unsigned        mismatches;
    bit                 gaps_on;
    int unsigned        hold_req;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_cylindrical_tensor_component_top: done, errors");
        $finish;
    end

    // rotation element (sel, k) about z, Q2.30
    function automatic longint rot_elem(input logic [1:0] sel, input int k,
                                        input longint c, input longint s);
        case (sel)
            SEL_RADIAL: return (k == 0) ? c : (k == 1) ? s : 0;
            SEL_HOOP:   return (k == 0) ? -s : (k == 1) ? c : 0;
            default:    return (k == 2) ? (longint'(1) << 30) : 0;
        endcase
    endfunction

    function automatic logic signed [31:0] rotated_component(input t_point p);
        longint dx, dy, c, s;
        longint unsigned ax, ay, m, r, q, bitv, cm, sm;
        logic signed [95:0] sum, acc;
        logic signed [95:0] v [3];
        dx = longint'(p.pos_x) - longint'(axis_x);
        dy = longint'(p.pos_y) - longint'(axis_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax == 0 && ay == 0) begin
            c = longint'(1) << 30;
            s = 0;
        end else begin
            m = (ax > ay) ? ax : ay;
            while (m < (64'd1 << 30)) begin
                ax = ax << 1; ay = ay << 1; m = m << 1;
            end
            while (m >= (64'd1 << 31)) begin
                ax = ax >> 1; ay = ay >> 1; m = m >> 1;
            end
            q = ax * ax + ay * ay;
            r = 0;
            bitv = 64'd1 << 62;
            while (bitv > q) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (q >= r + bitv) begin
                    q = q - (r + bitv);
                    r = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
            cm = ((ax << 30) + (r >> 1)) / r;
            sm = ((ay << 30) + (r >> 1)) / r;
            c = (dx < 0) ? -longint'(cm) : longint'(cm);
            s = (dy < 0) ? -longint'(sm) : longint'(sm);
        end
        for (int k = 0; k < 3; k++) begin
            sum = '0;
            for (int l = 0; l < 3; l++)
                sum += 96'(p.t[3*k+l]) * 96'(rot_elem(sel_col, l, c, s));
            v[k] = (sum + (96'sd1 <<< 29)) >>> 30;
        end
        acc = '0;
        for (int k = 0; k < 3; k++)
            acc += 96'(rot_elem(sel_row, k, c, s)) * v[k];
        acc = (acc + (96'sd1 <<< 29)) >>> 30;
        if (acc > 96'sd2147483647) return 32'sh7fff_ffff;
        if (acc < -96'sd2147483648) return 32'sh8000_0000;
        return acc[31:0];
    endfunction

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return $signed(32'($urandom_range(0, 1 << 21))) - (1 << 20);
            3:       return $signed(32'($urandom_range(0, 1 << 17))) - (1 << 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_point rand_point();
        t_point p;
        p.pos_x = ($urandom_range(0, 9) == 0) ? axis_x : rand_q();
        p.pos_y = ($urandom_range(0, 9) == 0) ? axis_y : rand_q();
        for (int k = 0; k < 9; k++) p.t[k] = rand_q();
        return p;
    endfunction

    // random idle before an item; lowers valid only when a gap is taken
    task automatic input_gap();
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic send_point(input t_point p);
        input_gap();
        in_ch.valid <= 1'b1;
        in_ch.pos_x <= p.pos_x;
        in_ch.pos_y <= p.pos_y;
        in_ch.t_xx  <= p.t[0];
        in_ch.t_xy  <= p.t[1];
        in_ch.t_xz  <= p.t[2];
        in_ch.t_yx  <= p.t[3];
        in_ch.t_yy  <= p.t[4];
        in_ch.t_yz  <= p.t[5];
        in_ch.t_zx  <= p.t[6];
        in_ch.t_zy  <= p.t[7];
        in_ch.t_zz  <= p.t[8];
        do @(posedge i_clk); while (!in_ch.ready);
        expected_components.push_back(rotated_component(p));
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        in_ch.valid <= 1'b0;
        wait (expected_components.size() == 0);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_CENTER_X: axis_x = value;
            CFG_CENTER_Y: axis_y = value;
            CFG_ROW_SEL:  sel_row = value[1:0];
            default:      sel_col = value[1:0];
        endcase
    endtask

    task automatic set_axes(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [1:0] rs, input logic [1:0] cs);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_ROW_SEL, {30'd0, rs});
        write_reg(CFG_COL_SEL, {30'd0, cs});
    endtask

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                stall_left = hold_req;
                hold_req = 0;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 15);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_components.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_ch.component);
            end else if (out_ch.component !== expected_components[0]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("component mismatch: expected %h actual %h",
                             expected_components[0], out_ch.component);
                void'(expected_components.pop_front());
            end else begin
                void'(expected_components.pop_front());
            end
        end
    end

    task automatic test_directed();
        t_point p;
        // point on the axis, tensor entries 1.0 to 9.0 in Q16.16
        for (int k = 0; k < 9; k++) p.t[k] = 32'sd65536 * (k + 1);
        p.pos_x = 0; p.pos_y = 0;
        send_point(p);
        // row selectors 0 to 2 with column selectors 0 and 3, row selector three with every column
        for (int rs = 0; rs < 4; rs++) begin
            for (int cs = 0; cs < 4; cs += (rs == 3) ? 1 : 3) begin
                set_axes(32'h0001_0000, 32'hffff_0000, rs[1:0], cs[1:0]);
                p.pos_x = 32'sh0003_0000; p.pos_y = 32'sh0005_8000;
                send_point(p);
            end
        end
        // extreme fields, large offsets from extreme centers
        set_axes(32'h8000_0000, 32'h7fff_ffff, SEL_RADIAL, SEL_HOOP);
        for (int k = 0; k < 9; k++) p.t[k] = 32'sh7fff_ffff;
        p.pos_x = 32'sh7fff_ffff; p.pos_y = 32'sh8000_0000;
        send_point(p);
        for (int k = 0; k < 9; k++) p.t[k] = 32'sh8000_0000;
        p.pos_x = 32'sh7fff_ffff; p.pos_y = 32'sh7fff_fff0;
        send_point(p);
        p.pos_x = 32'sh8000_0000; p.pos_y = 32'sh7fff_ffff;
        send_point(p);
        p.pos_x = 32'sh8000_0001; p.pos_y = 32'sh8000_0000;
        send_point(p);
        p.pos_x = 32'sh0000_0001; p.pos_y = 32'sh7fff_fffe;
        send_point(p);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            set_axes(rand_q(), rand_q(), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)));
            repeat (80) send_point(rand_point());
        end
    endtask

    task automatic test_backpressure();
        set_axes(0, 0, SEL_HOOP, SEL_HOOP);
        hold_req = 300;
        repeat (150) send_point(rand_point());
    endtask

    task automatic test_unbroken_stream();
        set_axes(32'h7fff_ffff, 32'h8000_0000, SEL_ALIAS, SEL_RADIAL);
        gaps_on = 1'b0;
        repeat (60) send_point(rand_point());
    endtask

    initial begin
        mismatches = 0;
        gaps_on = 1'b1;
        hold_req = 0;
        axis_x = 0; axis_y = 0; sel_row = SEL_RADIAL; sel_col = SEL_RADIAL;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.pos_x = '0; in_ch.pos_y = '0;
        in_ch.t_xx = '0; in_ch.t_xy = '0; in_ch.t_xz = '0;
        in_ch.t_yx = '0; in_ch.t_yy = '0; in_ch.t_yz = '0;
        in_ch.t_zx = '0; in_ch.t_zy = '0; in_ch.t_zz = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_CENTER_X;
        cfg_ch.data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phases();
        test_backpressure();
        test_unbroken_stream();

        in_ch.valid <= 1'b0;
        wait (expected_components.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_components.size() == 0) begin
            $display("tb_cylindrical_tensor_component_top: done, clean");
        end else begin
            $display("tb_cylindrical_tensor_component_top: done, errors");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/core/cts_pkg.sv
rtl/core/cts_ifs.sv
rtl/core/cts_sqrt.sv
rtl/core/cts_div.sv
rtl/core/cylindrical_tensor_component_top.sv
dv/tb_cylindrical_tensor_component_top.sv
